// ===== hdl/ebsf_pkg.sv =====
// ----------------------------------------------------------------------------
// ebsf_pkg
// Types and constants shared by the escaped block stream framer modules.
// ----------------------------------------------------------------------------
package ebsf_pkg;

   localparam int MAX_RESULTS = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic       ACT_DATA = 1'b0;
   localparam logic       ACT_EOF  = 1'b1;

   localparam logic [7:0] ESCAPE_BYTE    = 8'h08;
   localparam logic [7:0] ESCAPE_OFFSET  = 8'h60;
   localparam logic [7:0] ESCAPE_LIMIT   = 8'h20;
   localparam logic [7:0] END_BYTE       = 8'h11;
   localparam logic [7:0] EOF_BYTE       = 8'h1A;
   localparam logic [7:0] FILL_BYTE      = 8'h00;
   localparam logic [7:0] START_CHECKSUM = 8'h3F;
   localparam logic [7:0] CLEAR_CHECKSUM = 8'h00;
   localparam int         START_POSITION = 3;
   localparam logic [8:0] MAX_REPEAT     = 9'h1FF;
   localparam logic [8:0] SINGLE         = 9'd1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [8:0] repeat_count;
      logic       block_end;
   } ent_type;

   typedef struct packed {
      ent_type [MAX_RESULTS-1:0] ent;
      logic [2:0]                num;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic rec_type put(rec_type r, logic [7:0] b, logic [8:0] cnt, logic e);
      rec_type t;
      t = r;
      t.ent[t.num] = '{out_byte: b, repeat_count: cnt, block_end: e};
      t.num = t.num + 3'd1;
      return t;
   endfunction

endpackage

// ===== hdl/ebsf_front.sv =====
// ----------------------------------------------------------------------------
// ebsf_front
// Accepts input words, tracks block position and checksum, and builds the
// list of output words each input causes.
// ----------------------------------------------------------------------------
module ebsf_front import ebsf_pkg::*; #(
   parameter int BLOCK_FILL_END = 510
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_action,
   input  logic [7:0]   req_data_byte,
   input  q_status_type q_status,
   output logic         push,
   output rec_type      push_rec
);

   localparam int              POS_W    = $clog2(BLOCK_FILL_END + 1);
   localparam logic [POS_W-1:0] FILL_END = POS_W'(BLOCK_FILL_END);
   localparam logic [POS_W-1:0] CLOSE_AT = POS_W'(BLOCK_FILL_END - 1);
   localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_TWO  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_INIT = POS_W'(START_POSITION);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       ck_ff, ck_in;
   logic [7:0]       ck_new;
   logic [7:0]       enc;
   logic [POS_W-1:0] pos_p1;
   logic             esc, close1, close2;
   rec_type          rec;

   function automatic logic [8:0] fill_of(logic [POS_W-1:0] q);
      logic [POS_W+8:0] d;
      d = (POS_W+9)'(FILL_END - q);
      if (d > (POS_W+9)'(MAX_REPEAT)) begin
         return MAX_REPEAT;
      end
      return d[8:0];
   endfunction

   function automatic rec_type add_close(rec_type r, logic [POS_W-1:0] q, logic [7:0] k);
      rec_type t;
      t = r;
      if (q < FILL_END) begin
         t = put(t, FILL_BYTE, fill_of(q), 1'b0);
      end
      t = put(t, k, SINGLE, 1'b0);
      t = put(t, END_BYTE, SINGLE, 1'b1);
      return t;
   endfunction

   assign push   = req_valid && !q_status.full;
   assign ck_new = ck_ff + req_data_byte;
   assign enc    = req_data_byte + ESCAPE_OFFSET;
   assign esc    = req_data_byte < ESCAPE_LIMIT;
   assign pos_p1 = pos_ff + POS_ONE;
   assign close1 = pos_ff >= CLOSE_AT;
   assign close2 = !close1 && (pos_p1 >= CLOSE_AT);

   always_comb begin
      rec    = '0;
      pos_in = pos_ff;
      ck_in  = ck_ff;
      if (req_action == ACT_EOF) begin
         rec    = put(rec, EOF_BYTE, SINGLE, 1'b0);
         rec    = add_close(rec, pos_p1, ck_ff);
         pos_in = POS_INIT;
         ck_in  = START_CHECKSUM;
      end else if (esc) begin
         if (close1) begin
            rec = add_close(rec, pos_ff, ck_new);
         end
         rec = put(rec, ESCAPE_BYTE, SINGLE, 1'b0);
         if (close2) begin
            rec = add_close(rec, pos_p1, ck_new);
         end
         rec = put(rec, enc, SINGLE, 1'b0);
         if (close1) begin
            pos_in = POS_TWO + POS_ONE;
         end else if (close2) begin
            pos_in = POS_TWO;
         end else begin
            pos_in = pos_ff + POS_TWO;
         end
         ck_in = (close1 || close2) ? CLEAR_CHECKSUM : ck_new;
      end else begin
         if (close1) begin
            rec = add_close(rec, pos_ff, ck_new);
         end
         rec    = put(rec, req_data_byte, SINGLE, 1'b0);
         pos_in = close1 ? POS_TWO : pos_p1;
         ck_in  = close1 ? CLEAR_CHECKSUM : ck_new;
      end
   end

   assign push_rec = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_INIT;
         ck_ff  <= START_CHECKSUM;
      end else if (push) begin
         pos_ff <= pos_in;
         ck_ff  <= ck_in;
      end
   end

endmodule

// ===== hdl/ebsf_queue.sv =====
// ----------------------------------------------------------------------------
// ebsf_queue
// Two-entry queue of per-word result lists between front and back.
// ----------------------------------------------------------------------------
module ebsf_queue import ebsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rec_type      push_rec,
   input  logic         pop,
   output rec_type      head_rec,
   output q_status_type q_status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rec_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   assign q_status.full  = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign q_status.empty = cnt_ff == '0;
   assign head_rec       = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_rec;
      end
   end

endmodule

// ===== hdl/ebsf_back.sv =====
// ----------------------------------------------------------------------------
// ebsf_back
// Walks the head result list one output word per cycle into the output
// register, while rsp_ready does not hold the register back.
// ----------------------------------------------------------------------------
module ebsf_back import ebsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rec_type      head_rec,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_out_byte,
   output logic [8:0]   rsp_repeat_count,
   output logic         rsp_block_end,
   output logic         rsp_last
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   ent_type    ent_ff;
   logic       last_ff;
   logic       head_valid, load, at_last;
   ent_type    cur;

   assign head_valid = !q_status.empty;
   assign load       = head_valid && (!valid_ff || rsp_ready);
   assign cur        = head_rec.ent[idx_ff];
   assign at_last    = idx_ff == head_rec.num - 3'd1;
   assign pop        = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = at_last ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff  <= cur;
         last_ff <= at_last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = ent_ff.out_byte;
   assign rsp_repeat_count = ent_ff.repeat_count;
   assign rsp_block_end    = ent_ff.block_end;
   assign rsp_last         = last_ff;

`ifndef SYNTHESIS
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count != 9'd0)
      else $error("zero repeat count");
   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_out_byte == END_BYTE)
      else $error("block end without end byte");
   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_repeat_count > SINGLE |-> rsp_out_byte == FILL_BYTE)
      else $error("repeat on non-fill byte");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff < head_rec.num)
      else $error("index past result list");
`endif

endmodule

// ===== hdl/escaped_block_stream_framer.sv =====
// ----------------------------------------------------------------------------
// escaped_block_stream_framer
// Frames a file byte stream into checksummed, escaped fixed-size blocks.
// ----------------------------------------------------------------------------
// Each input word produces one to five output words; the back end emits one
// output word per cycle while rsp_ready does not hold it back. A plain byte
// causes one word and an escaped byte two; closing a block gives up to five
// and ending the file up to four. The front end takes a new input word
// every cycle while the two-entry queue between front and back has room;
// zero fill goes out as a single word with a repeat count.
module escaped_block_stream_framer import ebsf_pkg::*; #(
   parameter int BLOCK_FILL_END = 510
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [8:0] rsp_repeat_count,
   output logic       rsp_block_end,
   output logic       rsp_last
);

   q_status_type q_status;
   logic         push, pop;
   rec_type      push_rec, head_rec;

   assign req_ready = !q_status.full;

   ebsf_front #(.BLOCK_FILL_END(BLOCK_FILL_END)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .q_status      (q_status),
      .push          (push),
      .push_rec      (push_rec)
   );

   ebsf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_status (q_status)
   );

   ebsf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_rec         (head_rec),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_block_end    (rsp_block_end),
      .rsp_last         (rsp_last)
   );

endmodule
